// ===== rtl/ssrg_pkg.sv =====
// ssrg_pkg: shared types, codes and constants of the stepper step-rate generator.
// Used by every module of the block except ssrg_div; depends on nothing.
package ssrg_pkg;

  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned CLK_W      = 27;
  localparam int unsigned CMP_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  localparam int unsigned LEVEL_MIN_RST = 0;
  localparam int unsigned LEVEL_MAX_RST = 100;
  localparam int unsigned FREQ_MIN_RST  = 100;
  localparam int unsigned FREQ_MAX_RST  = 2000;
  localparam int unsigned CPU_CLOCK_RST = 16000000;

  localparam int unsigned DEFAULT_LEVEL_DEF = 50;
  localparam int unsigned PRESCALE_DEF      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_CLOCK = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_LEVEL  = 2'd1,
    CMD_DIR    = 2'd2,
    CMD_ENABLE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREQ_GO,
    ST_FREQ_DIV,
    ST_CMP_GO,
    ST_CMP_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic item_en;
    logic lvl_load;
    logic div_start;
    logic div_cmp;
    logic freq_load;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/ssrg_div.sv =====
// ssrg_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing but its width parameter.
module ssrg_div #(
  parameter int unsigned DivW = 27
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [DivW:0]   shifted;
  logic [DivW:0]   diff;
  logic            ge;

  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[DivW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DivW-1:0] : shifted[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/ssrg_ctrl.sv =====
// ssrg_ctrl: sequencing state machine and stream handshakes of the generator.
// Depends on ssrg_pkg; drives the datapath through dp_cmd_t.
module ssrg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  ssrg_pkg::cmd_e    s_cmd_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output ssrg_pkg::dp_cmd_t dp_cmd_o,
  input  ssrg_pkg::dp_stat_t dp_stat_i
);
  import ssrg_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        ov_q, ov_d;
  logic        out_free;
  logic        accept;

  assign out_free  = ~ov_q | m_ready_i;
  assign s_ready_o = (state_q == ST_IDLE) & out_free;
  assign accept    = s_ready_o & s_valid_i;
  assign m_valid_o = ov_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && s_cmd_i == CMD_LEVEL) state_d = ST_FREQ_GO;
      end
      ST_FREQ_GO:  state_d = ST_FREQ_DIV;
      ST_FREQ_DIV: begin
        if (dp_stat_i.div_done) state_d = ST_CMP_GO;
      end
      ST_CMP_GO:   state_d = ST_CMP_DIV;
      ST_CMP_DIV: begin
        if (dp_stat_i.div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    dp_cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        dp_cmd_o.item_en  = accept & (s_cmd_i != CMD_LEVEL);
        dp_cmd_o.lvl_load = accept & (s_cmd_i == CMD_LEVEL);
      end
      ST_FREQ_GO:  dp_cmd_o.div_start = 1'b1;
      ST_FREQ_DIV: dp_cmd_o.freq_load = dp_stat_i.div_done;
      ST_CMP_GO: begin
        dp_cmd_o.div_start = 1'b1;
        dp_cmd_o.div_cmp   = 1'b1;
      end
      ST_CMP_DIV:  dp_cmd_o = '0;
      ST_DONE:     dp_cmd_o.commit = out_free;
      default:     dp_cmd_o = '0;
    endcase
    ov_d = (ov_q & ~m_ready_i) | dp_cmd_o.item_en | dp_cmd_o.commit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// ===== rtl/ssrg_dp.sv =====
// ssrg_dp: configuration registers, step state, level-to-compare arithmetic.
// Depends on ssrg_pkg and ssrg_div; steered by ssrg_ctrl.
module ssrg_dp #(
  parameter int unsigned DEFAULT_LEVEL = ssrg_pkg::DEFAULT_LEVEL_DEF,
  parameter int unsigned PRESCALE      = ssrg_pkg::PRESCALE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ssrg_pkg::dp_cmd_t                  cmd_i,
  output ssrg_pkg::dp_stat_t                 stat_o,
  input  ssrg_pkg::cmd_e                     item_cmd_i,
  input  logic [ssrg_pkg::LEVEL_W-1:0]       item_level_i,
  input  logic                               item_flag_i,
  input  logic                               cfg_we_i,
  input  logic [ssrg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ssrg_pkg::CLK_W-1:0]         cfg_data_i,
  output logic                               step_o,
  output logic                               dir_o,
  output logic                               enable_n_o,
  output logic [ssrg_pkg::CMP_W-1:0]         compare_o,
  output logic [ssrg_pkg::LEVEL_W-1:0]       level_o
);
  import ssrg_pkg::*;

  localparam int unsigned DenW  = 17 + $clog2(PRESCALE);
  localparam int unsigned DivW  = (DenW > CLK_W) ? DenW : CLK_W;
  localparam int unsigned Scale = 2 * PRESCALE;
  localparam int unsigned ProdW = LEVEL_W + FREQ_W;

  // compare value for the default level under the reset register values
  localparam int unsigned RstLvlLo = (DEFAULT_LEVEL < LEVEL_MIN_RST) ? LEVEL_MIN_RST
                                                                     : DEFAULT_LEVEL;
  localparam int unsigned RstLvl   = (RstLvlLo > LEVEL_MAX_RST) ? LEVEL_MAX_RST : RstLvlLo;
  localparam int unsigned RstSteps = (LEVEL_MAX_RST > LEVEL_MIN_RST)
                                     ? (LEVEL_MAX_RST - LEVEL_MIN_RST) : 1;
  localparam int unsigned RstFreq  =
      (LEVEL_MAX_RST <= LEVEL_MIN_RST) ? FREQ_MIN_RST :
      (FREQ_MAX_RST >= FREQ_MIN_RST)
        ? FREQ_MIN_RST + ((RstLvl - LEVEL_MIN_RST) * (FREQ_MAX_RST - FREQ_MIN_RST)) / RstSteps
        : FREQ_MIN_RST - ((RstLvl - LEVEL_MIN_RST) * (FREQ_MIN_RST - FREQ_MAX_RST)) / RstSteps;
  localparam int unsigned RstDen   = Scale * RstFreq;
  localparam int unsigned RstQuot  = (RstDen == 0) ? 0 : CPU_CLOCK_RST / (RstDen + 0);
  localparam int unsigned RstCmp   = (RstQuot == 0) ? 65535 :
                                     ((RstQuot - 1) > 65535) ? 65535 : (RstQuot - 1);

  logic [LEVEL_W-1:0] lmin_q, lmax_q;
  logic [FREQ_W-1:0]  fmin_q, fmax_q;
  logic [CLK_W-1:0]   clk_q;

  logic [CMP_W-1:0]   tick_q, tick_d;
  logic [CMP_W-1:0]   cmp_q, cmp_d;
  logic [LEVEL_W-1:0] lvl_q, lvl_d;
  logic               phase_q, phase_d;
  logic               step_q, step_d;
  logic               fwd_q, fwd_d;
  logic               run_q, run_d;

  logic [LEVEL_W-1:0] nlvl_q;
  logic [ProdW-1:0]   prod_q;
  logic [LEVEL_W-1:0] steps_q;
  logic               guard_q;
  logic               rise_q;
  logic [DenW-1:0]    denom_q;

  logic [LEVEL_W-1:0] lv_lo, lv_c, off;
  logic               rise;
  logic [FREQ_W-1:0]  span;
  logic [FREQ_W-1:0]  scaled;
  logic [FREQ_W-1:0]  freq;
  logic [DivW-1:0]    dividend, divisor, quot, qm1;
  logic [CMP_W-1:0]   cmp_new;
  logic               div_done;

  // level clamp and offset product
  always_comb begin
    lv_lo = (item_level_i < lmin_q) ? lmin_q : item_level_i;
    lv_c  = (lv_lo > lmax_q) ? lmax_q : lv_lo;
    off   = lv_c - lmin_q;
    rise  = fmax_q >= fmin_q;
    span  = rise ? (fmax_q - fmin_q) : (fmin_q - fmax_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lvl_load) begin
      nlvl_q  <= lv_c;
      prod_q  <= ProdW'(off) * ProdW'(span);
      steps_q <= lmax_q - lmin_q;
      guard_q <= lmax_q <= lmin_q;
      rise_q  <= rise;
    end
    if (cmd_i.freq_load) begin
      denom_q <= DenW'(freq) * DenW'(Scale);
    end
  end

  assign dividend = cmd_i.div_cmp ? DivW'(clk_q) : DivW'(prod_q);
  assign divisor  = cmd_i.div_cmp ? DivW'(denom_q) : DivW'(steps_q);

  ssrg_div #(
    .DivW(DivW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign stat_o.div_done = div_done;

  always_comb begin
    scaled = quot[FREQ_W-1:0];
    if (guard_q) begin
      freq = fmin_q;
    end else if (rise_q) begin
      freq = fmin_q + scaled;
    end else begin
      freq = fmin_q - scaled;
    end
    qm1 = quot - 1'b1;
    if (quot == '0 || denom_q == '0) begin
      cmp_new = '1;
    end else if (|qm1[DivW-1:CMP_W]) begin
      cmp_new = '1;
    end else begin
      cmp_new = qm1[CMP_W-1:0];
    end
  end

  // step state update
  always_comb begin
    tick_d  = tick_q;
    cmp_d   = cmp_q;
    lvl_d   = lvl_q;
    phase_d = phase_q;
    step_d  = step_q;
    fwd_d   = fwd_q;
    run_d   = run_q;
    if (cmd_i.item_en) begin
      case (item_cmd_i)
        CMD_TICK: begin
          if (run_q) begin
            if (tick_q == cmp_q) begin
              tick_d  = '0;
              phase_d = ~phase_q;
              step_d  = ~phase_q;
            end else begin
              tick_d = tick_q + 1'b1;
            end
          end
        end
        CMD_DIR:    fwd_d = item_flag_i;
        CMD_ENABLE: begin
          run_d = item_flag_i;
          if (item_flag_i) begin
            tick_d = '0;
          end else begin
            step_d = 1'b0;
          end
        end
        default: tick_d = tick_q;
      endcase
    end
    if (cmd_i.commit) begin
      lvl_d = nlvl_q;
      cmp_d = cmp_new;
      if (tick_q > cmp_new) tick_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lmin_q  <= LEVEL_W'(LEVEL_MIN_RST);
      lmax_q  <= LEVEL_W'(LEVEL_MAX_RST);
      fmin_q  <= FREQ_W'(FREQ_MIN_RST);
      fmax_q  <= FREQ_W'(FREQ_MAX_RST);
      clk_q   <= CLK_W'(CPU_CLOCK_RST);
      tick_q  <= '0;
      cmp_q   <= CMP_W'(RstCmp);
      lvl_q   <= LEVEL_W'(RstLvl);
      phase_q <= 1'b0;
      step_q  <= 1'b0;
      fwd_q   <= 1'b1;
      run_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LEVEL_MIN: lmin_q <= cfg_data_i[LEVEL_W-1:0];
          REG_LEVEL_MAX: lmax_q <= cfg_data_i[LEVEL_W-1:0];
          REG_FREQ_MIN:  fmin_q <= cfg_data_i[FREQ_W-1:0];
          REG_FREQ_MAX:  fmax_q <= cfg_data_i[FREQ_W-1:0];
          REG_CPU_CLOCK: clk_q  <= cfg_data_i;
          default:       clk_q  <= clk_q;
        endcase
      end
      tick_q  <= tick_d;
      cmp_q   <= cmp_d;
      lvl_q   <= lvl_d;
      phase_q <= phase_d;
      step_q  <= step_d;
      fwd_q   <= fwd_d;
      run_q   <= run_d;
    end
  end

  assign step_o     = step_q;
  assign dir_o      = fwd_q;
  assign enable_n_o = ~run_q;
  assign compare_o  = cmp_q;
  assign level_o    = lvl_q;

endmodule

// ===== rtl/stepper_step_rate_generator.sv =====
// Stepper step-rate generator: one command beat in, one pin-state beat out. Tick, direction
// and enable commands update the state registers directly and can follow each other every
// cycle while the output side takes its beats. A speed-level command runs two passes of one
// shared radix-2 divider (offset scaling, then clock over step frequency), which is 27 bits
// wide for a prescale up to 1024; no new command is taken before its result beat is issued.
// The result beat stays in the state registers until taken; a new command is taken in the
// cycle the pending beat is taken.
// Depends on ssrg_pkg, ssrg_ctrl, ssrg_dp and ssrg_div.
module stepper_step_rate_generator #(
  parameter int unsigned DEFAULT_LEVEL = ssrg_pkg::DEFAULT_LEVEL_DEF,
  parameter int unsigned PRESCALE      = ssrg_pkg::PRESCALE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ssrg_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // level[7:0], flag[8]
  input  logic [ssrg_pkg::IN_USER_W-1:0]    s_axis_tuser,  // cmd[1:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ssrg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // step_out[0], dir_out[1],
                                                           // enable_n[2], compare_now[18:3],
                                                           // level_now[26:19]
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssrg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssrg_pkg::CLK_W-1:0]        cfg_data_i
);
  import ssrg_pkg::*;

  dp_cmd_t            dp_cmd;
  dp_stat_t           dp_stat;
  cmd_e               item_cmd;
  logic               step_out, dir_out, enable_n;
  logic [CMP_W-1:0]   compare_now;
  logic [LEVEL_W-1:0] level_now;

  assign item_cmd    = cmd_e'(s_axis_tuser);
  assign cfg_ready_o = 1'b1;

  ssrg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_cmd_i  (item_cmd),
    .s_ready_o(s_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .dp_cmd_o (dp_cmd),
    .dp_stat_i(dp_stat)
  );

  ssrg_dp #(
    .DEFAULT_LEVEL(DEFAULT_LEVEL),
    .PRESCALE     (PRESCALE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .item_cmd_i  (item_cmd),
    .item_level_i(s_axis_tdata[LEVEL_W-1:0]),
    .item_flag_i (s_axis_tdata[LEVEL_W]),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_o      (step_out),
    .dir_o       (dir_out),
    .enable_n_o  (enable_n),
    .compare_o   (compare_now),
    .level_o     (level_now)
  );

  assign m_axis_tdata = {5'd0, level_now, compare_now, enable_n, dir_out, step_out};

endmodule

// ===== rtl/ssrg_chk.sv =====
// ssrg_chk: port-level checks of the step-rate generator, bound to the top level.
// Depends on ssrg_pkg.
module ssrg_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [ssrg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [ssrg_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ssrg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ssrg_pkg::*;

  logic acc;
  assign acc = s_axis_tvalid & s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser != CMD_LEVEL |=> m_axis_tvalid)
    else $error("no result beat after a one-cycle command");

  a_level_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser == CMD_LEVEL |=> !s_axis_tready)
    else $error("input taken while a speed level is computed");

  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser == CMD_DIR |=> m_axis_tdata[1] == $past(s_axis_tdata[8]))
    else $error("direction pin does not follow command");

  a_disable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser == CMD_ENABLE && !s_axis_tdata[8]
    |=> m_axis_tdata[2] && !m_axis_tdata[0])
    else $error("disable did not drop step pin and enable");

endmodule

bind stepper_step_rate_generator ssrg_chk u_ssrg_chk (.*);

// ===== sim/stepper_step_rate_generator_tb.sv =====
// Self-checking bench for stepper_step_rate_generator: drives command beats and register
// writes, predicts every pin-state beat in a scoreboard class and checks each one.
// Depends on ssrg_pkg and the stepper_step_rate_generator RTL.
module stepper_step_rate_generator_tb;
  import ssrg_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned SETTLE_CYC = 64;
  localparam int unsigned PHASE_BEATS = 200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [4:0]  pad;
    logic [7:0]  level_now;
    logic [15:0] compare_now;
    logic        enable_n;
    logic        dir_out;
    logic        step_out;
  } pin_beat_t;

  class step_rate_scoreboard;
    logic [7:0]  lvl_lo, lvl_hi;
    logic [15:0] hz_lo, hz_hi;
    logic [26:0] clk_hz;
    logic [15:0] ticks, cmp;
    logic [7:0]  level;
    logic        phase, step_pin, fwd, run;
    pin_beat_t   pins_due[$];
    int unsigned fails;

    function new();
      lvl_lo   = 8'(LEVEL_MIN_RST);
      lvl_hi   = 8'(LEVEL_MAX_RST);
      hz_lo    = 16'(FREQ_MIN_RST);
      hz_hi    = 16'(FREQ_MAX_RST);
      clk_hz   = 27'(CPU_CLOCK_RST);
      ticks    = '0;
      phase    = 1'b0;
      step_pin = 1'b0;
      fwd      = 1'b1;
      run      = 1'b0;
      fails    = 0;
      take_level(8'(DEFAULT_LEVEL_DEF));
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CLK_W-1:0] data);
      case (idx)
        REG_LEVEL_MIN: lvl_lo = data[7:0];
        REG_LEVEL_MAX: lvl_hi = data[7:0];
        REG_FREQ_MIN:  hz_lo  = data[15:0];
        REG_FREQ_MAX:  hz_hi  = data[15:0];
        REG_CPU_CLOCK: clk_hz = data;
        default: ;
      endcase
    endfunction

    function int unsigned rate_for_level(logic [7:0] lv);
      int unsigned span, off, lo, hi;
      lo = 32'(hz_lo);
      hi = 32'(hz_hi);
      if (lvl_hi <= lvl_lo) return lo;
      span = int'(lvl_hi) - int'(lvl_lo);
      off  = int'(lv) - int'(lvl_lo);
      if (hi >= lo) return lo + (off * (hi - lo)) / span;
      return lo - (off * (lo - hi)) / span;
    endfunction

    function logic [15:0] compare_for_rate(int unsigned hz);
      longint unsigned div, q;
      div = longint'(PRESCALE_DEF) * 2 * longint'(hz);
      if (div == 0) return 16'hFFFF;
      q = longint'(clk_hz) / div;
      if (q == 0) return 16'hFFFF;
      q = q - 1;
      if (q > 65535) q = 65535;
      return q[15:0];
    endfunction

    function void take_level(logic [7:0] lv);
      logic [7:0] v;
      v = lv;
      if (v < lvl_lo) v = lvl_lo;
      if (v > lvl_hi) v = lvl_hi;
      level = v;
      cmp   = compare_for_rate(rate_for_level(v));
      if (ticks > cmp) ticks = '0;
    endfunction

    function void note_command(cmd_e c, logic [7:0] lv, logic fl);
      pin_beat_t p;
      case (c)
        CMD_TICK: begin
          if (run) begin
            if (ticks == cmp) begin
              ticks    = '0;
              phase    = ~phase;
              step_pin = phase;
            end else begin
              ticks = ticks + 16'd1;
            end
          end
        end
        CMD_LEVEL: take_level(lv);
        CMD_DIR: fwd = fl;
        CMD_ENABLE: begin
          run = fl;
          if (fl) ticks = '0;
          else step_pin = 1'b0;
        end
        default: ;
      endcase
      p             = '0;
      p.step_out    = step_pin;
      p.dir_out     = fwd;
      p.enable_n    = ~run;
      p.compare_now = cmp;
      p.level_now   = level;
      pins_due.push_back(p);
    endfunction

    function void report(string what, int unsigned exp_v, int unsigned got_v);
      fails++;
      if (fails <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
    endfunction

    function void check_pins(logic [OUT_DATA_W-1:0] data);
      pin_beat_t got, exp_p;
      got = data;
      if (pins_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected beat: got %h", data);
        return;
      end
      exp_p = pins_due.pop_front();
      if (got.step_out != exp_p.step_out)
        report("step_out", 32'(exp_p.step_out), 32'(got.step_out));
      if (got.dir_out != exp_p.dir_out)
        report("dir_out", 32'(exp_p.dir_out), 32'(got.dir_out));
      if (got.enable_n != exp_p.enable_n)
        report("enable_n", 32'(exp_p.enable_n), 32'(got.enable_n));
      if (got.compare_now != exp_p.compare_now)
        report("compare_now", 32'(exp_p.compare_now), 32'(got.compare_now));
      if (got.level_now != exp_p.level_now)
        report("level_now", 32'(exp_p.level_now), 32'(got.level_now));
    endfunction

    function int unsigned pending();
      return pins_due.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // level[7:0], flag[8]
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;  // cmd[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // step_out[0], dir_out[1], enable_n[2],
                                        // compare_now[18:3], level_now[26:19]
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CLK_W-1:0]      cfg_data_i    = '0;

  logic                  calm = 1'b0;
  int unsigned           idle_cycles = 0;
  step_rate_scoreboard   sb = new();

  stepper_step_rate_generator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 28);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_pins(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("stepper_step_rate_generator_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_command(input cmd_e c, input logic [7:0] lv, input logic fl);
    if (!calm) begin
      while ($urandom_range(0, 99) < 28) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, fl, lv};
    s_axis_tuser  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_command(c, lv, fl);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  // drain all beats, then write the full register set while the block is idle
  task automatic load_settings(input int unsigned lo, input int unsigned hi,
                               input int unsigned f_lo, input int unsigned f_hi,
                               input int unsigned clk_hz);
    logic [CLK_W-1:0] junk;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    junk = CLK_W'($urandom);
    write_register(REG_LEVEL_MIN, {junk[CLK_W-1:8], 8'(lo)});
    junk = CLK_W'($urandom);
    write_register(REG_LEVEL_MAX, {junk[CLK_W-1:8], 8'(hi)});
    junk = CLK_W'($urandom);
    write_register(REG_FREQ_MIN, {junk[CLK_W-1:16], 16'(f_lo)});
    junk = CLK_W'($urandom);
    write_register(REG_FREQ_MAX, {junk[CLK_W-1:16], 16'(f_hi)});
    write_register(REG_CPU_CLOCK, CLK_W'(clk_hz));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 72) send_command(CMD_TICK, 8'($urandom), 1'($urandom));
    else if (r < 82) send_command(CMD_LEVEL, 8'($urandom_range(0, 255)), 1'($urandom));
    else if (r < 90) send_command(CMD_DIR, 8'($urandom), 1'($urandom));
    else send_command(CMD_ENABLE, 8'($urandom), $urandom_range(0, 4) != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: disabled tick, direction, level extremes, enable
    send_command(CMD_TICK, 8'hFF, 1'b1);
    send_command(CMD_DIR, 8'h00, 1'b0);
    send_command(CMD_DIR, 8'hAA, 1'b1);
    send_command(CMD_LEVEL, 8'd0, 1'b0);
    send_command(CMD_LEVEL, 8'd255, 1'b1);
    send_command(CMD_LEVEL, 8'd50, 1'b0);
    send_command(CMD_ENABLE, 8'h55, 1'b0);
    send_command(CMD_ENABLE, 8'h00, 1'b1);
    send_command(CMD_TICK, 8'h00, 1'b0);
    send_command(CMD_TICK, 8'h00, 1'b0);

    // full ranges: saturated compare at the slowest level
    load_settings(0, 255, 1, 65535, 100000000);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    write_register(REG_SPARE, CLK_W'($urandom));
    cfg_valid_i <= 1'b0;
    send_command(CMD_LEVEL, 8'd0, 1'b1);
    send_command(CMD_LEVEL, 8'd255, 1'b0);

    // inverted level range, compare of one so the phase toggles fast
    load_settings(10, 5, 1, 65535, 32);
    send_command(CMD_LEVEL, 8'd0, 1'b0);
    send_command(CMD_TICK, 8'd0, 1'b0);
    send_command(CMD_TICK, 8'd0, 1'b0);
    send_command(CMD_TICK, 8'd0, 1'b0);
    send_command(CMD_ENABLE, 8'd0, 1'b0);
    send_command(CMD_TICK, 8'd0, 1'b0);
    send_command(CMD_ENABLE, 8'd0, 1'b1);
    send_command(CMD_TICK, 8'd0, 1'b0);

    // zero quotient
    load_settings(10, 5, 1, 65535, 1);
    send_command(CMD_LEVEL, 8'd7, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_settings(0, 255, 1, 65535, 100000000);
        1: load_settings(20, 200, 1, 40, 2000);
        2: load_settings(0, 255, 50, 3, 4000);
        3: load_settings(100, 100, 7, 9, 1000);
        5: load_settings(LEVEL_MIN_RST, LEVEL_MAX_RST, FREQ_MIN_RST, FREQ_MAX_RST,
                         CPU_CLOCK_RST);
        7: load_settings(5, 250, 65535, 1, 100000000);
        default:
          load_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 300),
                        $urandom_range(1, 300), $urandom_range(1, 60000));
      endcase
      calm = (ph == 6);
      for (int n = 0; n < PHASE_BEATS; n++) random_command();
    end

    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("stepper_step_rate_generator_tb: PASS");
    end else begin
      $display("stepper_step_rate_generator_tb: FAIL");
    end
    $finish;
  end

endmodule
